### hdl/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// shared constants, codes and port structs of the log byte ring
// ----------------------------------------------------------------------------
`default_nettype none

package lbr_pkg;

  localparam int RING_BYTES = 65536;
  localparam int RING_AW    = $clog2(RING_BYTES);
  localparam int MAX_READ   = 64;

  localparam int POS_W    = 48;
  localparam int REC_W    = 64;
  localparam int BYTE_W   = 8;
  localparam int LEVEL_W  = 4;
  localparam int BUDGET_W = 7;
  localparam int CFG_IW   = 2;

  localparam logic [LEVEL_W-1:0]  TOP_LEVEL    = LEVEL_W'(8);
  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = LEVEL_W'(6);
  localparam logic [BUDGET_W-1:0] MAX_READ_B   = BUDGET_W'(MAX_READ);
  localparam logic [POS_W-1:0]    RING_BYTES_P = POS_W'(RING_BYTES);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_LEVEL  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_ENABLE = CFG_IW'(1);

  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
  } ram_rd_t;

endpackage

`default_nettype wire

### hdl/lbr_ram.sv
// ----------------------------------------------------------------------------
// lbr_ram
// byte store of the ring: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_ram (
  input  wire                           clk,
  input  wire lbr_pkg::ram_wr_t         wr,
  input  wire lbr_pkg::ram_rd_t         rd,
  output logic [lbr_pkg::BYTE_W-1:0]    rd_data
);

  logic [lbr_pkg::BYTE_W-1:0] mem [lbr_pkg::RING_BYTES];
  logic [lbr_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/log_byte_ring_with_cursor_reads.sv
// ----------------------------------------------------------------------------
// log_byte_ring_with_cursor_reads
// trace-log byte ring with appends and reads from an absolute cursor
// ----------------------------------------------------------------------------
// an append result is registered in the cycle after the item is taken; a read
// passes the clamp, count and setup steps, then the ram read stream gives one
// byte a cycle via the ram read and output registers unless the output stalls;
// an empty read answers from the empty state. 1 append per cycle unless the
// output stalls; a read holds the input until its last byte is loaded
// reset: head, record count and the other control registers; ring not cleared
`default_nettype none

module log_byte_ring_with_cursor_reads (
  input  wire                                 clk,
  input  wire                                 rst_n,

  input  wire                                 cfg_we,
  input  wire  [lbr_pkg::CFG_IW-1:0]          cfg_index,
  input  wire  [lbr_pkg::LEVEL_W-1:0]         cfg_wdata,

  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_opcode,
  input  wire  [lbr_pkg::BYTE_W-1:0]          in_data_byte,
  input  wire  [lbr_pkg::LEVEL_W-1:0]         in_severity,
  input  wire                                 in_record_end,
  input  wire  [lbr_pkg::POS_W-1:0]           in_read_cursor,
  input  wire  [lbr_pkg::BUDGET_W-1:0]        in_read_budget,

  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [lbr_pkg::BYTE_W-1:0]          out_out_byte,
  output logic                                out_byte_valid,
  output logic [lbr_pkg::POS_W-1:0]           out_byte_position,
  output logic [lbr_pkg::POS_W-1:0]           out_next_cursor,
  output logic                                out_last,
  output logic [lbr_pkg::POS_W-1:0]           out_write_head,
  output logic [lbr_pkg::REC_W-1:0]           out_records_logged
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLAMP  = 6'b000010,
    S_COUNT  = 6'b000100,
    S_SETUP  = 6'b001000,
    S_EMPTY  = 6'b010000,
    S_STREAM = 6'b100000
  } state_t;

  localparam int PW = lbr_pkg::POS_W;
  localparam int BW = lbr_pkg::BUDGET_W;

  // control
  state_t                        state_r, state_nxt;
  logic [lbr_pkg::LEVEL_W-1:0]   level_r, level_nxt;
  logic                          enable_r, enable_nxt;
  logic [PW-1:0]                 head_r, head_nxt;
  logic [lbr_pkg::REC_W-1:0]     rec_r, rec_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          pend_r, pend_nxt;
  logic [BW-1:0]                 rem_r, rem_nxt;

  // read working registers
  logic [PW-1:0]                 cursor_r, cursor_nxt;
  logic [BW-1:0]                 budget_r, budget_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [BW-1:0]                 n_r, n_nxt;
  logic [PW-1:0]                 next_r, next_nxt;
  logic [PW-1:0]                 rd_pos_r, rd_pos_nxt;
  logic [PW-1:0]                 ppos_r, ppos_nxt;
  logic                          plast_r, plast_nxt;

  // output payload
  logic [lbr_pkg::BYTE_W-1:0]    ob_r, ob_nxt;
  logic                          obv_r, obv_nxt;
  logic [PW-1:0]                 opos_r, opos_nxt;
  logic [PW-1:0]                 onext_r, onext_nxt;
  logic                          olast_r, olast_nxt;
  logic [PW-1:0]                 ohead_r, ohead_nxt;
  logic [lbr_pkg::REC_W-1:0]     orec_r, orec_nxt;

  lbr_pkg::ram_wr_t              ram_wr;
  lbr_pkg::ram_rd_t              ram_rd;
  logic [lbr_pkg::BYTE_W-1:0]    ram_dout;

  logic                          out_free;
  logic                          in_acc;
  logic                          store;
  logic                          load;
  logic                          issue;
  logic [PW-1:0]                 oldest;
  logic [PW:0]                   diff;

  lbr_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_dout)
  );

  assign out_free = !out_valid_r || !out_stall;
  // interlock: no item enters while a read is in flight
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign store    = in_acc && (in_opcode == lbr_pkg::OP_APPEND) && enable_r &&
                    (in_severity <= level_r);

  assign oldest = (head_r[PW-1:lbr_pkg::RING_AW] != '0) ?
                  head_r - lbr_pkg::RING_BYTES_P : '0;
  assign diff   = {1'b0, head_r} - {1'b0, pos_r};

  assign load  = (state_r == S_STREAM) && pend_r && out_free;
  assign issue = (state_r == S_STREAM) && (rem_r != '0) && (!pend_r || load);

  always_comb begin
    ram_wr.en   = store;
    ram_wr.addr = head_r[lbr_pkg::RING_AW-1:0];
    ram_wr.data = in_data_byte;
    ram_rd.en   = issue;
    ram_rd.addr = rd_pos_r[lbr_pkg::RING_AW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    enable_nxt    = enable_r;
    head_nxt      = head_r;
    rec_nxt       = rec_r;
    out_valid_nxt = out_valid_r && out_stall;
    pend_nxt      = pend_r;
    rem_nxt       = rem_r;
    cursor_nxt    = cursor_r;
    budget_nxt    = budget_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    next_nxt      = next_r;
    rd_pos_nxt    = rd_pos_r;
    ppos_nxt      = ppos_r;
    plast_nxt     = plast_r;
    ob_nxt        = ob_r;
    obv_nxt       = obv_r;
    opos_nxt      = opos_r;
    onext_nxt     = onext_r;
    olast_nxt     = olast_r;
    ohead_nxt     = ohead_r;
    orec_nxt      = orec_r;

    if (cfg_we) begin
      case (cfg_index)
        lbr_pkg::CFG_LEVEL: begin
          if (cfg_wdata <= lbr_pkg::TOP_LEVEL) begin
            level_nxt = cfg_wdata;
          end
        end
        lbr_pkg::CFG_ENABLE: begin
          enable_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == lbr_pkg::OP_APPEND) begin
            if (store) begin
              head_nxt = head_r + PW'(1);
              if (in_record_end) begin
                rec_nxt = rec_r + lbr_pkg::REC_W'(1);
              end
            end
            out_valid_nxt = 1'b1;
            ob_nxt        = '0;
            obv_nxt       = 1'b0;
            opos_nxt      = '0;
            onext_nxt     = '0;
            olast_nxt     = 1'b1;
            ohead_nxt     = head_nxt;
            orec_nxt      = rec_nxt;
          end else begin
            cursor_nxt = in_read_cursor;
            budget_nxt = (in_read_budget > lbr_pkg::MAX_READ_B) ?
                         lbr_pkg::MAX_READ_B : in_read_budget;
            state_nxt  = S_CLAMP;
          end
        end
      end
      S_CLAMP: begin
        pos_nxt   = (cursor_r < oldest) ? oldest : cursor_r;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        // nothing available when the head is at or behind the cursor
        if (diff[PW] || (diff == '0)) begin
          n_nxt = '0;
        end else if ((diff[PW-1:BW] == '0) && (diff[BW-1:0] < budget_r)) begin
          n_nxt = diff[BW-1:0];
        end else begin
          n_nxt = budget_r;
        end
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        next_nxt   = pos_r + PW'(n_r);
        rd_pos_nxt = pos_r;
        rem_nxt    = n_r;
        pend_nxt   = 1'b0;
        state_nxt  = (n_r == '0) ? S_EMPTY : S_STREAM;
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ob_nxt        = '0;
          obv_nxt       = 1'b0;
          opos_nxt      = pos_r;
          onext_nxt     = next_r;
          olast_nxt     = 1'b1;
          ohead_nxt     = head_r;
          orec_nxt      = rec_r;
          state_nxt     = S_IDLE;
        end
      end
      S_STREAM: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          ob_nxt        = ram_dout;
          obv_nxt       = 1'b1;
          opos_nxt      = ppos_r;
          onext_nxt     = next_r;
          olast_nxt     = plast_r;
          ohead_nxt     = head_r;
          orec_nxt      = rec_r;
          pend_nxt      = 1'b0;
          if (plast_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (issue) begin
          pend_nxt   = 1'b1;
          ppos_nxt   = rd_pos_r;
          plast_nxt  = (rem_r == BW'(1));
          rd_pos_nxt = rd_pos_r + PW'(1);
          rem_nxt    = rem_r - BW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= lbr_pkg::LEVEL_RESET;
      enable_r    <= 1'b1;
      head_r      <= '0;
      rec_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      enable_r    <= enable_nxt;
      head_r      <= head_nxt;
      rec_r       <= rec_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r <= cursor_nxt;
    budget_r <= budget_nxt;
    pos_r    <= pos_nxt;
    n_r      <= n_nxt;
    next_r   <= next_nxt;
    rd_pos_r <= rd_pos_nxt;
    ppos_r   <= ppos_nxt;
    plast_r  <= plast_nxt;
    ob_r     <= ob_nxt;
    obv_r    <= obv_nxt;
    opos_r   <= opos_nxt;
    onext_r  <= onext_nxt;
    olast_r  <= olast_nxt;
    ohead_r  <= ohead_nxt;
    orec_r   <= orec_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_out_byte       = ob_r;
  assign out_byte_valid     = obv_r;
  assign out_byte_position  = opos_r;
  assign out_next_cursor    = onext_r;
  assign out_last           = olast_r;
  assign out_write_head     = ohead_r;
  assign out_records_logged = orec_r;

`ifndef SYNTHESIS
  a_pend_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_STREAM)
    else $error("ram read pending outside the read stream");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STREAM |-> rem_r <= lbr_pkg::MAX_READ_B)
    else $error("read byte count above limit");

  a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(head_r)) |-> head_r == $past(head_r) + PW'(1))
    else $error("head moved by other than one");

  a_last_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && out_byte_valid) |->
      out_next_cursor == out_byte_position + PW'(1))
    else $error("final byte does not end at the next cursor");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the log byte ring: a directed table of appends,
// reads and register writes, then random record traffic under three idling
// mixes; each result is compared field by field against a typed table entry or
// a cycle-free model of the ring
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_W     = lbr_pkg::BYTE_W;
  localparam int LEVEL_W    = lbr_pkg::LEVEL_W;
  localparam int POS_W      = lbr_pkg::POS_W;
  localparam int BUDGET_W   = lbr_pkg::BUDGET_W;
  localparam int REC_W      = lbr_pkg::REC_W;
  localparam int CFG_IW     = lbr_pkg::CFG_IW;
  localparam int RING_BYTES = lbr_pkg::RING_BYTES;

  typedef struct {
    logic                op;
    logic [BYTE_W-1:0]   data;
    logic [LEVEL_W-1:0]  sev;
    logic                rend;
    logic [POS_W-1:0]    cursor;
    logic [BUDGET_W-1:0] budget;
  } ring_item_t;

  typedef struct {
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_ok;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  nxt;
    logic              last;
    logic [POS_W-1:0]  head;
    logic [REC_W-1:0]  recs;
  } ring_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               typed;
    ring_item_t         it;
    ring_result_t       res;
    logic [CFG_IW-1:0]  reg_idx;
    logic [LEVEL_W-1:0] reg_val;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [LEVEL_W-1:0]  cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_opcode;
  logic [BYTE_W-1:0]   in_data_byte;
  logic [LEVEL_W-1:0]  in_severity;
  logic                in_record_end;
  logic [POS_W-1:0]    in_read_cursor;
  logic [BUDGET_W-1:0] in_read_budget;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_out_byte;
  logic                out_byte_valid;
  logic [POS_W-1:0]    out_byte_position;
  logic [POS_W-1:0]    out_next_cursor;
  logic                out_last;
  logic [POS_W-1:0]    out_write_head;
  logic [REC_W-1:0]    out_records_logged;

  // model state of the ring
  logic [BYTE_W-1:0]  ring_mem [RING_BYTES];
  logic [POS_W-1:0]   pred_head;
  logic [REC_W-1:0]   pred_recs;
  logic [LEVEL_W-1:0] pred_level;
  logic               pred_enable;

  ring_result_t ring_results_q [$];
  ring_result_t staged_q [$];
  plan_row_t    plan [$];

  int tx_idle_pct = 20;
  int rx_idle_pct = 53;
  int fail_count  = 0;

  log_byte_ring_with_cursor_reads dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .in_severity        (in_severity),
    .in_record_end      (in_record_end),
    .in_read_cursor     (in_read_cursor),
    .in_read_budget     (in_read_budget),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_byte_position  (out_byte_position),
    .out_next_cursor    (out_next_cursor),
    .out_last           (out_last),
    .out_write_head     (out_write_head),
    .out_records_logged (out_records_logged)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic ring_result_t make_res(logic [BYTE_W-1:0] b, logic ok,
                                            logic [POS_W-1:0] p, logic [POS_W-1:0] n,
                                            logic lst);
    ring_result_t r;
    r.rd_byte = b;
    r.rd_ok   = ok;
    r.pos     = p;
    r.nxt     = n;
    r.last    = lst;
    r.head    = pred_head;
    r.recs    = pred_recs;
    return r;
  endfunction

  // fills staged_q with the results the item causes and updates the state
  function automatic void predict_ring_item(ring_item_t it);
    logic [POS_W-1:0]    oldest;
    logic [POS_W-1:0]    start;
    logic [POS_W-1:0]    avail;
    logic [POS_W-1:0]    count;
    logic [POS_W-1:0]    p;
    logic [BUDGET_W-1:0] bud;
    staged_q.delete();
    if (it.op == lbr_pkg::OP_APPEND) begin
      if (pred_enable && it.sev <= pred_level) begin
        ring_mem[int'(pred_head % lbr_pkg::RING_BYTES_P)] = it.data;
        pred_head = pred_head + 1'b1;
        if (it.rend) pred_recs = pred_recs + 1'b1;
      end
      staged_q.push_back(make_res('0, 1'b0, '0, '0, 1'b1));
      return;
    end
    oldest = (pred_head > lbr_pkg::RING_BYTES_P) ? pred_head - lbr_pkg::RING_BYTES_P : '0;
    start  = (it.cursor < oldest) ? oldest : it.cursor;
    avail  = (pred_head > start) ? pred_head - start : '0;
    bud    = (it.budget > lbr_pkg::MAX_READ_B) ? lbr_pkg::MAX_READ_B : it.budget;
    count  = (avail < POS_W'(bud)) ? avail : POS_W'(bud);
    if (count == '0) begin
      staged_q.push_back(make_res('0, 1'b0, start, start, 1'b1));
      return;
    end
    for (int i = 0; i < int'(count); i++) begin
      p = start + POS_W'(i);
      staged_q.push_back(make_res(ring_mem[int'(p % lbr_pkg::RING_BYTES_P)], 1'b1, p,
                                  start + count, i == int'(count) - 1));
    end
  endfunction

  // --------------------------------------------------------------- driving

  task automatic send_item(input ring_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= it.op;
    in_data_byte   <= it.data;
    in_severity    <= it.sev;
    in_record_end  <= it.rend;
    in_read_cursor <= it.cursor;
    in_read_budget <= it.budget;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue(input ring_item_t it);
    send_item(it);
    predict_ring_item(it);
    foreach (staged_q[j]) ring_results_q.push_back(staged_q[j]);
  endtask

  // sender stops until every result is back and the read pipe has emptied
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [LEVEL_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == lbr_pkg::CFG_LEVEL) begin
      if (val <= lbr_pkg::TOP_LEVEL) pred_level = val;
    end else if (idx == lbr_pkg::CFG_ENABLE) begin
      pred_enable = val[0];
    end
  endtask

  function automatic ring_item_t append_item(logic [BYTE_W-1:0] d, logic [LEVEL_W-1:0] s,
                                             logic e);
    ring_item_t it;
    it.op     = lbr_pkg::OP_APPEND;
    it.data   = d;
    it.sev    = s;
    it.rend   = e;
    it.cursor = POS_W'({$urandom(), $urandom()});
    it.budget = BUDGET_W'($urandom());
    return it;
  endfunction

  function automatic ring_item_t read_item(logic [POS_W-1:0] c, logic [BUDGET_W-1:0] b);
    ring_item_t it;
    it.op     = lbr_pkg::OP_READ;
    it.data   = BYTE_W'($urandom());
    it.sev    = LEVEL_W'($urandom());
    it.rend   = 1'($urandom());
    it.cursor = c;
    it.budget = b;
    return it;
  endfunction

  function automatic ring_result_t append_res(logic [POS_W-1:0] h, logic [REC_W-1:0] n);
    ring_result_t r;
    r = '{rd_byte: '0, rd_ok: 1'b0, pos: '0, nxt: '0, last: 1'b1, head: h, recs: n};
    return r;
  endfunction

  function automatic ring_result_t empty_res(logic [POS_W-1:0] p, logic [POS_W-1:0] h,
                                            logic [REC_W-1:0] n);
    ring_result_t r;
    r = '{rd_byte: '0, rd_ok: 1'b0, pos: p, nxt: p, last: 1'b1, head: h, recs: n};
    return r;
  endfunction

  function automatic void add_row(ring_item_t it, logic typed, ring_result_t res);
    plan_row_t r;
    r.kind    = ROW_ITEM;
    r.typed   = typed;
    r.it      = it;
    r.res     = res;
    r.reg_idx = lbr_pkg::CFG_LEVEL;
    r.reg_val = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IW-1:0] idx, logic [LEVEL_W-1:0] val);
    plan_row_t r;
    r.kind    = ROW_CFG;
    r.typed   = 1'b0;
    r.it      = read_item('0, '0);
    r.res     = append_res('0, '0);
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  // random record traffic; count is the number of items to send
  task automatic run_traffic(input int count);
    int                 sent;
    int                 len;
    int                 pick;
    logic [LEVEL_W-1:0] lvl;
    logic [POS_W-1:0]   back;
    logic [POS_W-1:0]   cur;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // well-formed record: same level on every byte, end mark on the last
        len = $urandom_range(1, 8);
        lvl = LEVEL_W'($urandom_range(0, 8));
        for (int i = 0; i < len; i++)
          issue(append_item(BYTE_W'($urandom()), lvl, i == len - 1));
        sent += len;
      end else begin
        if (pick < 80) begin
          back = POS_W'($urandom_range(0, 80));
          cur  = (pred_head > back) ? pred_head - back : '0;
          issue(read_item(cur, BUDGET_W'($urandom())));
        end else if (pick < 87) begin
          issue(read_item(POS_W'({$urandom(), $urandom()}), BUDGET_W'($urandom())));
        end else if (pick < 93) begin
          // around the oldest retained byte once the ring has wrapped
          if (pred_head > lbr_pkg::RING_BYTES_P + 100 && $urandom_range(3) != 0)
            cur = pred_head - lbr_pkg::RING_BYTES_P - 100 + POS_W'($urandom_range(0, 200));
          else
            cur = '0;
          issue(read_item(cur, BUDGET_W'($urandom_range(0, 64))));
        end else begin
          issue(append_item(BYTE_W'($urandom()), LEVEL_W'($urandom()), 1'($urandom())));
        end
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ring_results_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = ring_results_q.pop_front();
        check_field("out_byte", want.rd_byte, out_out_byte);
        check_field("byte_valid", want.rd_ok, out_byte_valid);
        check_field("byte_position", want.pos, out_byte_position);
        check_field("next_cursor", want.nxt, out_next_cursor);
        check_field("last", want.last, out_last);
        check_field("write_head", want.head, out_write_head);
        check_field("records_logged", want.recs, out_records_logged);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = lbr_pkg::CFG_LEVEL;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_opcode      = lbr_pkg::OP_APPEND;
    in_data_byte   = '0;
    in_severity    = '0;
    in_record_end  = 1'b0;
    in_read_cursor = '0;
    in_read_budget = '0;
    pred_head      = '0;
    pred_recs      = '0;
    pred_level     = lbr_pkg::LEVEL_RESET;
    pred_enable    = 1'b1;

    add_row(read_item('0, '0), 1'b1, empty_res('0, '0, '0));
    add_row(read_item('1, '1), 1'b1, empty_res('1, '0, '0));
    add_row(append_item(8'hff, 4'd0, 1'b0), 1'b1, append_res(48'd1, 64'd0));
    add_row(append_item(8'h00, 4'd6, 1'b1), 1'b1, append_res(48'd2, 64'd1));
    // levels above the threshold are dropped
    add_row(append_item(8'h5a, 4'd7, 1'b1), 1'b1, append_res(48'd2, 64'd1));
    add_row(append_item(8'hc3, 4'd15, 1'b1), 1'b1, append_res(48'd2, 64'd1));
    add_row(read_item('0, 7'd127), 1'b0, append_res('0, '0));
    add_row(read_item(48'd1, 7'd1), 1'b0, append_res('0, '0));
    add_row(read_item(48'd2, 7'd5), 1'b1, empty_res(48'd2, 48'd2, 64'd1));
    add_cfg(lbr_pkg::CFG_LEVEL, lbr_pkg::TOP_LEVEL);
    add_row(append_item(8'ha5, 4'd8, 1'b1), 1'b1, append_res(48'd3, 64'd2));
    // out of range threshold leaves the old one in place
    add_cfg(lbr_pkg::CFG_LEVEL, 4'd15);
    add_row(append_item(8'h3c, 4'd9, 1'b1), 1'b1, append_res(48'd3, 64'd2));
    add_cfg(lbr_pkg::CFG_LEVEL, 4'd0);
    add_row(append_item(8'h11, 4'd1, 1'b1), 1'b1, append_res(48'd3, 64'd2));
    add_row(append_item(8'h80, 4'd0, 1'b1), 1'b1, append_res(48'd4, 64'd3));
    add_cfg(lbr_pkg::CFG_ENABLE, 4'd0);
    add_row(append_item(8'h7e, 4'd0, 1'b1), 1'b1, append_res(48'd4, 64'd3));
    add_row(read_item('0, 7'd64), 1'b0, append_res('0, '0));
    add_cfg(lbr_pkg::CFG_ENABLE, 4'd15);
    add_cfg(lbr_pkg::CFG_LEVEL, lbr_pkg::LEVEL_RESET);
    add_row(read_item(48'd3, 7'd0), 1'b1, empty_res(48'd3, 48'd4, 64'd3));
    // cursor ahead of the head is kept as given
    add_row(read_item(48'h0000_0001_0000, 7'd64), 1'b1,
            empty_res(48'h0000_0001_0000, 48'd4, 64'd3));
    add_row(append_item(8'h55, 4'd6, 1'b0), 1'b0, append_res('0, '0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        drain();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else if (plan[k].typed) begin
        send_item(plan[k].it);
        predict_ring_item(plan[k].it);
        ring_results_q.push_back(plan[k].res);
      end else begin
        issue(plan[k].it);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 53 : 0;
      rx_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 20 : 0;
      for (int c = 0; c < 3; c++) begin
        drain();
        write_reg(lbr_pkg::CFG_LEVEL, LEVEL_W'($urandom_range(0, 15)));
        write_reg(lbr_pkg::CFG_ENABLE, {3'($urandom()), 1'($urandom_range(4) != 0)});
        run_traffic(50);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
